// ----- hw/rtl/lfc_pkg.sv -----
// Shared types, codes and defaults for the layered framebuffer compositor.
`default_nettype none

package lfc_pkg;

	localparam int DEF_LAYER_SLOTS = 4;
	localparam int DEF_MAX_DIM     = 128;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// Item kinds
	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SCAN  = 2'd2;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_SCREEN_W  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SCREEN_H  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PITCH     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_LAYER_CNT = 3'd3;
	localparam logic [CFG_AW-1:0] REG_VIS_MASK  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_WIDTHS    = 3'd5;
	localparam logic [CFG_AW-1:0] REG_HEIGHTS   = 3'd6;

	// Largest scanned screen dimension
	localparam logic [7:0] SCAN_LIMIT = 8'd128;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_RUN,
		ST_CLEAR
	} lfc_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;
		logic sweep_en;
		logic sweep_all;
	} lfc_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clear_hit;
		logic sweep_last;
		logic s1_stall;
	} lfc_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfc_ctrl.sv -----
// Controller state machine: reset wipe, item acceptance, layer clear sweep.
`default_nettype none

module lfc_ctrl import lfc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire lfc_sts_t sts,
	output lfc_cmd_t      cmd
);

	lfc_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.accept && sts.clear_hit) state_nxt = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (sts.sweep_last) state_nxt = ST_RUN;
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.sweep_en  = 1'b0;
		cmd.sweep_all = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_en  = 1'b1;
				cmd.sweep_all = 1'b1;
			end
			ST_RUN: begin
				in_ready = !sts.s1_stall;
			end
			ST_CLEAR: begin
				cmd.sweep_en = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_valid && in_ready;
	end

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_INIT) |-> !cmd.accept)
		else $error("item transfer during a store sweep");

	a_clear_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.clear_hit) |=> (state_q == ST_CLEAR))
		else $error("layer clear did not start sweep");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_en && sts.sweep_last) |=> (state_q == ST_RUN))
		else $error("sweep did not return to run");

endmodule

`default_nettype wire

// ----- hw/rtl/lfc_dp.sv -----
// Datapath: config registers, layer stores, scan counters, compose and output stage.
`default_nettype none

module lfc_dp import lfc_pkg::*; #(
	parameter int LAYER_SLOTS = DEF_LAYER_SLOTS,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lfc_cmd_t          cmd,
	output lfc_sts_t               sts,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic [1:0]        kind,
	input  wire logic [1:0]        layer_sel,
	input  wire logic [6:0]        pos_x,
	input  wire logic [6:0]        pos_y,
	input  wire logic [31:0]       draw_color,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [18:0]            pixel_address,
	output logic [31:0]            pixel_color,
	output logic                   frame_end
);

	// Only four layers carry size bytes, so at most four stores are built
	localparam int LIVE    = (LAYER_SLOTS < 4) ? LAYER_SLOTS : 4;
	localparam int CELLS   = MAX_DIM * MAX_DIM;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

	// Config registers
	logic [7:0]  scr_w_q, scr_h_q;
	logic [12:0] pitch_q;
	logic [2:0]  lcnt_q;
	logic [3:0]  vis_q;
	logic [31:0] widths_q, heights_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q   <= '0;
			scr_h_q   <= '0;
			pitch_q   <= '0;
			lcnt_q    <= '0;
			vis_q     <= '0;
			widths_q  <= '0;
			heights_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_W:  scr_w_q   <= cfg_data[7:0];
				REG_SCREEN_H:  scr_h_q   <= cfg_data[7:0];
				REG_PITCH:     pitch_q   <= cfg_data[12:0];
				REG_LAYER_CNT: lcnt_q    <= cfg_data[2:0];
				REG_VIS_MASK:  vis_q     <= cfg_data[3:0];
				REG_WIDTHS:    widths_q  <= cfg_data;
				REG_HEIGHTS:   heights_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Item decode
	logic live_id;
	logic draw_in;
	logic draw_go;
	logic scan_go;
	logic [CELL_AW-1:0] draw_addr;

	always_comb begin
		live_id = ({1'b0, layer_sel} < lcnt_q) && (int'(layer_sel) < LIVE);
		draw_in = live_id
			&& ({1'b0, pos_x} < widths_q[8*layer_sel +: 8])  && (int'(pos_x) < MAX_DIM)
			&& ({1'b0, pos_y} < heights_q[8*layer_sel +: 8]) && (int'(pos_y) < MAX_DIM);
		draw_go = cmd.accept && (kind == KIND_DRAW) && draw_in;
		scan_go = cmd.accept && (kind == KIND_SCAN) && (scr_w_q != '0) && (scr_h_q != '0);
		draw_addr = CELL_AW'(int'(pos_y) * MAX_DIM + int'(pos_x));
	end

	// Sweep counter shared by reset wipe and layer clear
	logic [CELL_AW-1:0] sweep_q;
	logic [1:0]         clr_layer_q;
	logic               sweep_last;

	assign sweep_last = (sweep_q == CELL_AW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && kind == KIND_CLEAR) clr_layer_q <= layer_sel;
	end

	// Scan position: fix stale position, then step
	logic [6:0]  col_q, row_q;
	logic [7:0]  sw, sh, c8, r8, nc8, nr8;
	logic        last;
	logic [19:0] prod;
	logic [18:0] addr;
	logic [CELL_AW-1:0] scan_addr;

	always_comb begin
		sw = (scr_w_q > SCAN_LIMIT) ? SCAN_LIMIT : scr_w_q;
		sh = (scr_h_q > SCAN_LIMIT) ? SCAN_LIMIT : scr_h_q;
		c8 = {1'b0, col_q};
		r8 = {1'b0, row_q};
		if (c8 >= sw) begin
			c8 = '0;
			r8 = r8 + 8'd1;
		end
		if (r8 >= sh) r8 = '0;
		last = ((c8 + 8'd1) == sw) && ((r8 + 8'd1) == sh);
		nc8 = c8 + 8'd1;
		nr8 = r8;
		if (nc8 >= sw) begin
			nc8 = '0;
			nr8 = r8 + 8'd1;
			if (nr8 >= sh) nr8 = '0;
		end
		prod = 20'(r8[6:0]) * 20'(pitch_q);
		addr = 19'(prod + 20'(c8));
		scan_addr = CELL_AW'(int'(r8) * MAX_DIM + int'(c8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (scan_go) begin
			col_q <= nc8[6:0];
			row_q <= nr8[6:0];
		end
	end

	// Layer stores and scan stage 1
	logic [31:0]     rd_s1 [LIVE];
	logic            hit_s1 [LIVE];
	logic [18:0]     addr_s1;
	logic            last_s1;
	logic            s1_valid_q;
	logic            out_load;

	for (genvar l = 0; l < LIVE; l++) begin : g_lyr
		logic [31:0]        mem_q [CELLS];
		logic               we;
		logic [CELL_AW-1:0] wa;
		logic [31:0]        wd;
		logic               hit;

		always_comb begin
			we = (cmd.sweep_en && (cmd.sweep_all || clr_layer_q == 2'(l)))
				|| (draw_go && layer_sel == 2'(l));
			wa = cmd.sweep_en ? sweep_q : draw_addr;
			wd = cmd.sweep_en ? 32'h0000_0000 : draw_color;
			hit = vis_q[l] && (3'(l) < lcnt_q)
				&& (c8 < widths_q[8*l +: 8])  && (int'(c8) < MAX_DIM)
				&& (r8 < heights_q[8*l +: 8]) && (int'(r8) < MAX_DIM);
		end

		always_ff @(posedge clk) begin
			if (we) mem_q[wa] <= wd;
			if (scan_go) begin
				rd_s1[l]  <= mem_q[scan_addr];
				hit_s1[l] <= hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			addr_s1 <= addr;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (scan_go) begin
			s1_valid_q <= 1'b1;
		end else if (out_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Compose: highest layer with a nonzero pixel wins
	logic [31:0] color;

	always_comb begin
		color = 32'h0000_0000;
		for (int l = 0; l < LIVE; l++) begin
			if (hit_s1[l] && rd_s1[l] != 32'h0000_0000) color = rd_s1[l];
		end
	end

	// Output register
	logic        out_valid_q;
	logic [18:0] pix_addr_q;
	logic [31:0] pix_color_q;
	logic        frame_end_q;

	assign out_load = s1_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_addr_q  <= addr_s1;
			pix_color_q <= color;
			frame_end_q <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = pix_addr_q;
	assign pixel_color   = pix_color_q;
	assign frame_end     = frame_end_q;

	assign sts.clear_hit  = (kind == KIND_CLEAR) && live_id;
	assign sts.sweep_last = sweep_last;
	assign sts.s1_stall   = s1_valid_q && out_valid_q && !out_ready;

	a_stall_blocks_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.s1_stall |-> !scan_go)
		else $error("scan accepted over a held stage 1 result");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_valid_q) |=> out_valid_q)
		else $error("stage 1 result not moved to output");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_go |=> (s1_valid_q && ({1'b0, col_q} < sw || col_q == '0)))
		else $error("scan column left the screen");

endmodule

`default_nettype wire

// ----- hw/rtl/layered_framebuffer_compositor.sv -----
// Top level of the layered framebuffer compositor: controller plus datapath.
//
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// in      | in        | in_valid / in_ready  | kind, layer_sel, pos_x, pos_y, draw_color
// out     | out       | out_valid / out_ready| pixel_address, pixel_color, frame_end
//
// Scans stream at one per cycle while in_ready stays high; each result passes through
// the store read register, then the output register.
// A layer clear walks every cell of that layer's store with in_ready low.
// After reset all stores are wiped in one pass over all cells, in_ready low;
// configuration writes are taken during that pass.
// When a result waits in the output register and another in the read stage, in_ready
// drops until out_ready takes the first one.
`default_nettype none

module layered_framebuffer_compositor import lfc_pkg::*; #(
	parameter int LAYER_SLOTS = DEF_LAYER_SLOTS,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration writes
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	// item channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	input  wire logic [1:0]        layer_sel,
	input  wire logic [6:0]        pos_x,
	input  wire logic [6:0]        pos_y,
	input  wire logic [31:0]       draw_color,
	// pixel channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [18:0]            pixel_address,
	output logic [31:0]            pixel_color,
	output logic                   frame_end
);

	lfc_cmd_t cmd;
	lfc_sts_t sts;

	// Sequencing: reset wipe, transfer gating, clear sweep
	lfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores, scan position, compositing and the output register
	lfc_dp #(
		.LAYER_SLOTS (LAYER_SLOTS),
		.MAX_DIM     (MAX_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.layer_sel     (layer_sel),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.draw_color    (draw_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.frame_end     (frame_end)
	);

endmodule

`default_nettype wire

// ----- verif/layered_framebuffer_compositor_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the layered framebuffer compositor: directed table, then random phases.
module layered_framebuffer_compositor_tb;
	import lfc_pkg::*;

	// ------------------------------------------------------------------
	// Run shape
	// ------------------------------------------------------------------
	localparam int CELLS_PER_LAYER = DEF_MAX_DIM * DEF_MAX_DIM;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 244;   // non-ignored items per random phase
	localparam int TAIL_CYCLES     = 8;     // read reg + output reg, with margin
	localparam int HOLD_AT         = 300;   // pixel count at which the sink backs off
	localparam int HOLD_CYCLES     = 200;
	// A layer clear keeps in_ready low while it sweeps MAX_DIM^2 cells; allow four such sweeps.
	localparam int QUIET_LIMIT     = 4 * CELLS_PER_LAYER;
	localparam int MAX_REPORTS     = 100;   // keep the log readable on a bad build

	localparam logic [1:0]        KIND_UNUSED = 2'd3;
	localparam logic [CFG_AW-1:0] REG_UNUSED  = 3'd7;

	// How a table row is checked: by the predictor, as "no pixel", or as typed in
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_GIVEN
	} check_mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  layer;
		logic [6:0]  x;
		logic [6:0]  y;
		logic [31:0] color;
	} item_t;

	typedef struct packed {
		logic [18:0] addr;
		logic [31:0] color;
		logic        last;
	} pixel_t;

	typedef struct packed {
		logic              is_reg;
		logic [CFG_AW-1:0] reg_idx;
		logic [CFG_DW-1:0] reg_val;
		item_t             item;
		check_mode_t       chk;
		pixel_t            want;
	} plan_row_t;

	// ------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [CFG_AW-1:0] cfg_index  = '0;
	logic [CFG_DW-1:0] cfg_data   = '0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [1:0]        kind       = '0;
	logic [1:0]        layer_sel  = '0;
	logic [6:0]        pos_x      = '0;
	logic [6:0]        pos_y      = '0;
	logic [31:0]       draw_color = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [18:0]       pixel_address;
	logic [31:0]       pixel_color;
	logic              frame_end;

	layered_framebuffer_compositor u_top (.*);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: own copy of the layer stores, raster position and registers
	// ------------------------------------------------------------------
	logic [31:0] layer_px [CELLS_PER_LAYER * DEF_LAYER_SLOTS];
	int unsigned col_at   = 0;
	int unsigned row_at   = 0;
	logic [7:0]  scr_w    = '0;
	logic [7:0]  scr_h    = '0;
	logic [12:0] pitch    = '0;
	logic [2:0]  lay_cnt  = '0;
	logic [3:0]  vis_mask = '0;
	logic [31:0] dim_w    = '0;
	logic [31:0] dim_h    = '0;

	pixel_t      pixels_due[$];     // composited pixels still owed by the DUT
	int unsigned mismatches = 0;
	int unsigned quiet      = 0;    // cycles with no transfer on either channel
	bit          burst_tx   = 1'b0; // sender runs back to back while set

	// Effective layer size: one byte per layer, capped at MAX_DIM
	function automatic int unsigned layer_dim(input logic [31:0] dims, input int unsigned l);
		int unsigned d;
		d = 32'(dims[8*l +: 8]);
		return (d < DEF_MAX_DIM) ? d : DEF_MAX_DIM;
	endfunction

	function automatic int unsigned live_count();
		return (lay_cnt < DEF_LAYER_SLOTS) ? lay_cnt : DEF_LAYER_SLOTS;
	endfunction

	function automatic int unsigned scan_dim(input logic [7:0] r);
		return (r < SCAN_LIMIT) ? r : SCAN_LIMIT;
	endfunction

	// Applies one item to the predictor; returns 1 when it yields a pixel
	function automatic bit compose_item(input item_t it, output pixel_t pix);
		int unsigned n, sw, sh, i, base;
		logic [31:0] acc, v;
		bit emit;
		n    = live_count();
		emit = 1'b0;
		pix  = '0;
		case (it.kind)
		KIND_DRAW: begin
			if (it.layer < n && it.x < layer_dim(dim_w, it.layer) &&
			    it.y < layer_dim(dim_h, it.layer))
				layer_px[it.layer * CELLS_PER_LAYER + it.y * DEF_MAX_DIM + it.x] = it.color;
		end
		KIND_CLEAR: begin
			if (it.layer < n)
				for (i = 0; i < CELLS_PER_LAYER; i++)
					layer_px[it.layer * CELLS_PER_LAYER + i] = '0;
		end
		KIND_SCAN: begin
			sw = scan_dim(scr_w);
			sh = scan_dim(scr_h);
			// empty screen: no pixel, raster position untouched
			if (sw != 0 && sh != 0) begin
				// position left over from a larger screen wraps first
				if (col_at >= sw) begin
					col_at = 0;
					row_at++;
				end
				if (row_at >= sh)
					row_at = 0;
				// top-most visible layer with a nonzero pixel wins; zero is the key
				acc = '0;
				for (i = 0; i < n; i++) begin
					if (vis_mask[i] && col_at < layer_dim(dim_w, i) &&
					    row_at < layer_dim(dim_h, i)) begin
						v = layer_px[i * CELLS_PER_LAYER + row_at * DEF_MAX_DIM + col_at];
						if (v != '0)
							acc = v;
					end
				end
				base      = row_at * pitch + col_at;
				pix.addr  = base[18:0];           // address wraps at 2^19
				pix.color = acc;
				pix.last  = (col_at + 1 == sw) && (row_at + 1 == sh);
				emit      = 1'b1;
				col_at++;
				if (col_at >= sw) begin
					col_at = 0;
					row_at++;
					if (row_at >= sh)
						row_at = 0;
				end
			end
		end
		default: ;
		endcase
		return emit;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_AW-1:0] idx,
	                                      input logic [CFG_DW-1:0] val);
		plan_row_t row;
		row         = '0;
		row.is_reg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic [1:0] k, input logic [1:0] l,
	                                       input logic [6:0] x, input logic [6:0] y,
	                                       input logic [31:0] c, input check_mode_t chk,
	                                       input logic [18:0] a, input logic [31:0] pc,
	                                       input logic fe);
		plan_row_t row;
		row            = '0;
		row.item       = '{kind: k, layer: l, x: x, y: y, color: c};
		row.chk        = chk;
		row.want       = '{addr: a, color: pc, last: fe};
		return row;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// One register write per cycle; the caller drops cfg_we after the last one
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		REG_SCREEN_W:  scr_w    = val[7:0];
		REG_SCREEN_H:  scr_h    = val[7:0];
		REG_PITCH:     pitch    = val[12:0];
		REG_LAYER_CNT: lay_cnt  = val[2:0];
		REG_VIS_MASK:  vis_mask = val[3:0];
		REG_WIDTHS:    dim_w    = val;
		REG_HEIGHTS:   dim_h    = val;
		default: ;
		endcase
	endtask

	// Offer one item, hold it until the transfer, predict, then maybe idle
	task automatic send_item(input item_t it, input check_mode_t chk, input pixel_t want);
		pixel_t pix;
		int unsigned gap;
		in_valid   <= 1'b1;
		kind       <= it.kind;
		layer_sel  <= it.layer;
		pos_x      <= it.x;
		pos_y      <= it.y;
		draw_color <= it.color;
		do @(posedge clk); while (!in_ready);
		if (compose_item(it, pix) && chk == CHK_PREDICT)
			pixels_due.push_back(pix);
		if (chk == CHK_GIVEN)
			pixels_due.push_back(want);
		gap = $urandom_range(0, 8);
		if (burst_tx)
			gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Quiesce: all pixels back, any clear finished, then the pipeline tail
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0 || !in_ready);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Pixel checker: every transfer on the output channel is compared field by field
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				flag_mismatch($sformatf("pixel with none owed: addr %0d color %h last %b",
				                        pixel_address, pixel_color, frame_end));
			end else begin
				want = pixels_due.pop_front();
				if (pixel_address !== want.addr)
					flag_mismatch($sformatf("pixel_address %0d, wanted %0d",
					                        pixel_address, want.addr));
				if (pixel_color !== want.color)
					flag_mismatch($sformatf("pixel_color %h, wanted %h at addr %0d",
					                        pixel_color, want.color, want.addr));
				if (frame_end !== want.last)
					flag_mismatch($sformatf("frame_end %b, wanted %b at addr %0d",
					                        frame_end, want.last, want.addr));
			end
		end
	end

	// Watchdog: too long with no transfer anywhere means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pixel sink: random back-pressure, bursts of always-ready, and one long
	// hold-off so the two result slots fill and in_ready drops
	// ------------------------------------------------------------------
	initial begin : pixel_sink
		int unsigned wait_n, taken;
		bit burst_rx, held;
		taken    = 0;
		held     = 1'b0;
		burst_rx = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 40 == 0)
				burst_rx = ($urandom_range(0, 3) == 0);
			wait_n = $urandom_range(0, 8);
			if (burst_rx)
				wait_n = 0;
			if (!held && taken == HOLD_AT) begin
				wait_n = HOLD_CYCLES;
				held   = 1'b1;
			end
			if (wait_n != 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t   plan[$];
		item_t       it;
		int unsigned i, b, n, lim, r, phase, sent;
		logic [7:0]  sw_v, sh_v;
		logic [12:0] pitch_v;
		logic [2:0]  cnt_v;
		logic [3:0]  vis_v;
		logic [31:0] w_v, h_v;
		bit          in_cfg;

		for (i = 0; i < CELLS_PER_LAYER * DEF_LAYER_SLOTS; i++)
			layer_px[i] = '0;

		// Directed table. Registers start at zero: screen empty, no layers.
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // empty screen
		plan.push_back(item_row(KIND_UNUSED, 2'd3, 7'd127, 7'd127, 32'hFFFF_FFFF,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // unused kind
		plan.push_back(item_row(KIND_DRAW, 2'd0, 7'd0, 7'd0, 32'hDEAD_BEEF,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // no layer created
		plan.push_back(item_row(KIND_CLEAR, 2'd3, 7'd0, 7'd0, 32'h0,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // layer beyond count
		// 3x2 screen, max pitch, count above slots, layer 3 oversized (255 -> 128)
		plan.push_back(reg_row(REG_SCREEN_W, 32'd3));
		plan.push_back(reg_row(REG_SCREEN_H, 32'd2));
		plan.push_back(reg_row(REG_PITCH, 32'h1FFF));
		plan.push_back(reg_row(REG_LAYER_CNT, 32'd7));
		plan.push_back(reg_row(REG_VIS_MASK, 32'hF));
		plan.push_back(reg_row(REG_WIDTHS, 32'hFF80_0203));
		plan.push_back(reg_row(REG_HEIGHTS, 32'hFF80_0102));
		plan.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));            // must do nothing
		plan.push_back(item_row(KIND_DRAW, 2'd0, 7'd0, 7'd0, 32'hFFFF_FFFF,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_DRAW, 2'd1, 7'd1, 7'd0, 32'h0000_0001,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_DRAW, 2'd3, 7'd127, 7'd127, 32'hA5A5_A5A5,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // far corner, capped layer
		plan.push_back(item_row(KIND_DRAW, 2'd1, 7'd2, 7'd0, 32'h1234_5678,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // off the layer in x
		plan.push_back(item_row(KIND_DRAW, 2'd0, 7'd0, 7'd2, 32'h8765_4321,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // off the layer in y
		plan.push_back(item_row(KIND_DRAW, 2'd2, 7'd0, 7'd0, 32'h0,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // transparent over layer 0
		plan.push_back(item_row(KIND_DRAW, 2'd3, 7'd2, 7'd1, 32'h5A5A_5A5A,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_GIVEN, 19'd0, 32'hFFFF_FFFF, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_GIVEN, 19'd1, 32'h0000_0001, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_PREDICT, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_PREDICT, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_PREDICT, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_GIVEN, 19'd8193, 32'h5A5A_5A5A, 1'b1)); // end of frame
		plan.push_back(item_row(KIND_CLEAR, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_GIVEN, 19'd0, 32'h0, 1'b0));          // cleared, wrapped
		// Shrink the screen under the raster position; layers 1..3 lose their size
		plan.push_back(reg_row(REG_SCREEN_W, 32'd1));
		plan.push_back(reg_row(REG_SCREEN_H, 32'd255));
		plan.push_back(reg_row(REG_PITCH, 32'd4096));
		plan.push_back(reg_row(REG_LAYER_CNT, 32'd1));
		plan.push_back(reg_row(REG_VIS_MASK, 32'd1));
		plan.push_back(reg_row(REG_WIDTHS, 32'h0000_0080));
		plan.push_back(reg_row(REG_HEIGHTS, 32'h0000_0080));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_PREDICT, 19'd0, 32'h0, 1'b0));       // stale column wraps
		plan.push_back(item_row(KIND_DRAW, 2'd0, 7'd0, 7'd2, 32'h0000_0077,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_SCAN, 2'd0, 7'd0, 7'd0, 32'h0,
		                        CHK_PREDICT, 19'd0, 32'h0, 1'b0));
		plan.push_back(item_row(KIND_DRAW, 2'd1, 7'd0, 7'd0, 32'h0000_1234,
		                        CHK_NONE, 19'd0, 32'h0, 1'b0));          // layer no longer live

		// Reset once; the DUT then wipes its stores with in_ready low
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the table; register rows only after the block has gone idle
		in_cfg = 1'b0;
		foreach (plan[k]) begin
			if (plan[k].is_reg) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				write_reg(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				if (in_cfg) begin
					cfg_we <= 1'b0;
					in_cfg = 1'b0;
				end
				send_item(plan[k].item, plan[k].chk, plan[k].want);
			end
		end

		// Random phases, each under its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				// tall one-column screen at max pitch: address wraps past 2^19
				sw_v = 8'd1;   sh_v = 8'd255; pitch_v = 13'h1FFF;
				cnt_v = 3'd7;  vis_v = 4'hF;  w_v = 32'hFFFF_FFFF; h_v = 32'hFFFF_FFFF;
			end
			1: begin
				// largest screen, nothing created: every pixel is zero
				sw_v = 8'd255; sh_v = 8'd255; pitch_v = '0;
				cnt_v = '0;    vis_v = '0;    w_v = '0;            h_v = '0;
			end
			default: begin
				// mostly small screens so frames complete; sometimes anything
				sw_v    = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) :
				             $urandom_range(0, 255));
				sh_v    = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) :
				             $urandom_range(0, 255));
				r       = $urandom_range(0, 3);
				pitch_v = (r == 0) ? 13'h1FFF : (r == 1) ? 13'($urandom_range(0, 8191)) :
				          13'($urandom_range(0, 16));
				cnt_v   = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
				vis_v   = 4'($urandom_range(0, 15));
				for (b = 0; b < 4; b++) begin
					r = $urandom_range(0, 19);
					w_v[8*b +: 8] = (r < 12) ? 8'($urandom_range(0, 10)) :
					                (r < 15) ? 8'd128 : 8'($urandom_range(0, 255));
					r = $urandom_range(0, 19);
					h_v[8*b +: 8] = (r < 12) ? 8'($urandom_range(0, 10)) :
					                (r < 15) ? 8'd128 : 8'($urandom_range(0, 255));
				end
			end
			endcase

			drain();
			write_reg(REG_SCREEN_W, {24'h0, sw_v});
			write_reg(REG_SCREEN_H, {24'h0, sh_v});
			write_reg(REG_PITCH, {19'h0, pitch_v});
			write_reg(REG_LAYER_CNT, {29'h0, cnt_v});
			write_reg(REG_VIS_MASK, {28'h0, vis_v});
			write_reg(REG_WIDTHS, w_v);
			write_reg(REG_HEIGHTS, h_v);
			write_reg(REG_UNUSED, $urandom);
			cfg_we <= 1'b0;

			// Mostly draws into live layers inside the scanned area, and scans;
			// rare clears (each one stalls for a whole layer) and rare junk
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent % 48 == 0)
					burst_tx = ($urandom_range(0, 3) == 0);
				r       = $urandom_range(0, 99);
				it.kind = (r < 48) ? KIND_DRAW : (r < 96) ? KIND_SCAN :
				          (r < 97) ? KIND_CLEAR : KIND_UNUSED;
				n        = live_count();
				it.layer = 2'((n != 0 && $urandom_range(0, 99) < 85) ?
				              $urandom_range(0, n - 1) : $urandom_range(0, 3));
				lim = layer_dim(dim_w, it.layer);
				if (scan_dim(scr_w) < lim)
					lim = scan_dim(scr_w);
				it.x = 7'((lim != 0 && $urandom_range(0, 99) < 85) ?
				          $urandom_range(0, lim - 1) : $urandom_range(0, 127));
				lim = layer_dim(dim_h, it.layer);
				if (scan_dim(scr_h) < lim)
					lim = scan_dim(scr_h);
				it.y = 7'((lim != 0 && $urandom_range(0, 99) < 85) ?
				          $urandom_range(0, lim - 1) : $urandom_range(0, 127));
				it.color = ($urandom_range(0, 99) < 15) ? 32'h0 : $urandom;
				send_item(it, CHK_PREDICT, '0);
				if (it.kind != KIND_UNUSED)
					sent++;
			end
		end

		// Everything owed must arrive; the tail catches any stray extra pixel
		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
